[src/cbs_pkg.sv]
// cbs_pkg: shared types, codes and sizes for the closed b-spline smoother
// depends on nothing; imported by cbs_ctrl, cbs_dp and closed_bspline_smoother
`timescale 1ns / 1ps
package cbs_pkg;

  // ring capacity and derived widths
  localparam int MAX_POINTS = 256;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam logic [5:0] DENSITY_RST = 6'd8;

  // function codes
  localparam logic [1:0] FN_CLEAR  = 2'd0;
  localparam logic [1:0] FN_APPEND = 2'd1;
  localparam logic [1:0] FN_EMIT   = 2'd2;
  localparam logic [1:0] FN_IGNORE = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic       idle;
    logic       clear;
    logic       append;
    logic       emit;
    logic       err;
    logic       rd;
    logic       wgt;
    logic       mac;
    logic       div;
    logic       fin;
    logic       out_xfer;
    logic [5:0] step;
  } cbs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic empty;
    logic done;
    logic run_last;
  } cbs_stat_t;

endpackage

[src/cbs_ctrl.sv]
// cbs_ctrl: sequencer for append, clear and emit; drives handshakes and datapath steps
// depends on cbs_pkg
`timescale 1ns / 1ps
module cbs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_func,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              cfg_ready,
  output cbs_pkg::cbs_cmd_t cmd,
  input  cbs_pkg::cbs_stat_t st
);
  import cbs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_WGT  = 7'b0000100,
    S_MAC  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] step_r, step_nxt;
  logic       in_xfer, out_xfer;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r + 6'd1;
    case (state_r)
      S_IDLE: begin
        step_nxt = '0;
        if (in_xfer && in_func == FN_EMIT) begin
          if (st.empty || st.done) state_nxt = S_OUT;
          else                     state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (step_r == 6'd4) begin
          state_nxt = S_WGT;
          step_nxt  = '0;
        end
      end
      S_WGT: begin
        if (step_r == 6'd2) begin
          state_nxt = S_MAC;
          step_nxt  = '0;
        end
      end
      S_MAC: begin
        if (step_r == 6'd5) begin
          state_nxt = S_DIV;
          step_nxt  = '0;
        end
      end
      S_DIV: begin
        if (step_r == 6'd31) begin
          state_nxt = S_FIN;
          step_nxt  = '0;
        end
      end
      S_FIN: begin
        state_nxt = S_OUT;
        step_nxt  = '0;
      end
      S_OUT: begin
        step_nxt = '0;
        if (out_xfer) state_nxt = st.run_last ? S_IDLE : S_WGT;
      end
      default: begin
        state_nxt = S_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // commands
  always_comb begin
    cmd          = '0;
    cmd.idle     = (state_r == S_IDLE);
    cmd.clear    = in_xfer && in_func == FN_CLEAR;
    cmd.append   = in_xfer && in_func == FN_APPEND;
    cmd.emit     = in_xfer && in_func == FN_EMIT && !st.empty && !st.done;
    cmd.err      = in_xfer && in_func == FN_EMIT && (st.empty || st.done);
    cmd.rd       = (state_r == S_RD);
    cmd.wgt      = (state_r == S_WGT);
    cmd.mac      = (state_r == S_MAC);
    cmd.div      = (state_r == S_DIV);
    cmd.fin      = (state_r == S_FIN);
    cmd.out_xfer = out_xfer;
    cmd.step     = step_r;
  end

  // state machine checks
  a_rd_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD && step_r == 6'd4 |=> state_r == S_WGT)
    else $error("read phase did not hand over to weights");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && out_stall |=> state_r == S_OUT)
    else $error("result left while stalled");
  a_div_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && step_r == 6'd31 |=> state_r == S_FIN)
    else $error("divider ran past 32 steps");

endmodule

[src/cbs_dp.sv]
// cbs_dp: ring memory, weight generation, multiply-accumulate and restoring dividers
// depends on cbs_pkg; steered by cbs_ctrl
`timescale 1ns / 1ps
module cbs_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  cbs_pkg::cbs_cmd_t  cmd,
  output cbs_pkg::cbs_stat_t st,
  input  logic               cfg_valid,
  input  logic [5:0]         cfg_density,
  input  logic signed [31:0] in_x_in,
  input  logic signed [31:0] in_y_in,
  output logic signed [31:0] out_x_out,
  output logic signed [31:0] out_y_out,
  output logic               out_run_last,
  output logic               out_curve_last,
  output logic [1:0]         out_status
);
  import cbs_pkg::*;

  logic [5:0]              density_r;
  logic [CNT_W-1:0]        count_r, cursor_r;
  logic signed [31:0]      ring_x [MAX_POINTS];
  logic signed [31:0]      ring_y [MAX_POINTS];
  logic signed [31:0]      rd_x_r, rd_y_r;
  logic [ADDR_W-1:0]       idx_r [4];
  logic [5:0]              d_r, k_r, kmax_r;
  logic                    last_seg_r;
  logic signed [31:0]      p_r [2][4];
  logic [11:0]             kk_r, rr_r, dd_r;
  logic [17:0]             k3_r, r3_r, kkd_r, kdd_r, d3_r;
  logic [19:0]             w_r [4];
  logic [20:0]             den_r;
  logic signed [52:0]      prod_r [2];
  logic signed [55:0]      acc_r [2];
  logic                    neg_r [2];
  logic [20:0]             rem_r [2];
  logic [31:0]             lo_r [2], q_r [2];

  // emit set-up values
  logic [CNT_W-1:0] nm1, ip1, ip2;
  logic [5:0]       d_eff, r_w;
  logic             single, last_seg;
  logic [ADDR_W-1:0] a0, a2, a3;
  logic signed [23:0] w1_s, w2_s;

  assign st.empty    = (count_r == '0);
  assign st.done     = (cursor_r >= count_r);
  assign st.run_last = out_run_last;

  assign d_eff    = (density_r == 6'd0) ? 6'd1 : density_r;
  assign nm1      = count_r - 1'b1;
  assign ip1      = cursor_r + 1'b1;
  assign ip2      = cursor_r + 2'd2;
  assign single   = (count_r == CNT_W'(1));
  assign last_seg = (cursor_r == nm1);
  assign a0 = (cursor_r == '0) ? nm1[ADDR_W-1:0] : ADDR_W'(cursor_r - 1'b1);
  assign a2 = (ip1 == count_r) ? '0 : ip1[ADDR_W-1:0];
  assign a3 = single ? '0 : (ip2 >= count_r) ? ADDR_W'(ip2 - count_r) : ip2[ADDR_W-1:0];
  assign r_w = d_r - k_r;

  assign w1_s = 24'(3 * k3_r) - 24'(6 * kkd_r) + 24'(4 * d3_r);
  assign w2_s = 24'(3 * kkd_r) + 24'(3 * kdd_r) + 24'(d3_r) - 24'(3 * k3_r);

  // saturate a sign and magnitude quotient to 32 bits
  function automatic logic [31:0] sat32(input logic neg, input logic [31:0] q);
    logic [31:0] r;
    if (neg) r = (q > 32'h8000_0000) ? 32'h8000_0000 : (~q + 32'd1);
    else     r = q[31] ? 32'h7fff_ffff : q;
    return r;
  endfunction

  // control point ring
  always_ff @(posedge clk) begin
    if (cmd.append && count_r < CNT_W'(MAX_POINTS)) begin
      ring_x[count_r[ADDR_W-1:0]] <= in_x_in;
      ring_y[count_r[ADDR_W-1:0]] <= in_y_in;
    end
    rd_x_r <= ring_x[idx_r[cmd.step[1:0]]];
    rd_y_r <= ring_y[idx_r[cmd.step[1:0]]];
  end

  // control state: density, count, cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      density_r <= DENSITY_RST;
      count_r   <= '0;
      cursor_r  <= '0;
    end else begin
      if (cfg_valid && cmd.idle) density_r <= cfg_density;
      if (cmd.clear) begin
        count_r  <= '0;
        cursor_r <= '0;
      end
      if (cmd.append && count_r < CNT_W'(MAX_POINTS)) count_r <= count_r + 1'b1;
      if (cmd.out_xfer && out_run_last && out_status == ST_OK) cursor_r <= cursor_r + 1'b1;
    end
  end

  // segment set-up and point loading
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      idx_r[0]   <= a0;
      idx_r[1]   <= cursor_r[ADDR_W-1:0];
      idx_r[2]   <= a2;
      idx_r[3]   <= a3;
      d_r        <= d_eff;
      k_r        <= '0;
      kmax_r     <= single ? 6'd0 : last_seg ? d_eff : d_eff - 6'd1;
      last_seg_r <= last_seg;
    end
    if (cmd.out_xfer && !out_run_last) k_r <= k_r + 6'd1;
    if (cmd.rd && cmd.step != 6'd0) begin
      p_r[0][2'(cmd.step - 6'd1)] <= rd_x_r;
      p_r[1][2'(cmd.step - 6'd1)] <= rd_y_r;
    end
  end

  // weight generation: squares, then cubes and products, then weights and denominator
  always_ff @(posedge clk) begin
    if (cmd.wgt) begin
      case (cmd.step[1:0])
        2'd0: begin
          kk_r <= 12'(k_r * k_r);
          rr_r <= 12'(r_w * r_w);
          dd_r <= 12'(d_r * d_r);
        end
        2'd1: begin
          k3_r  <= 18'(kk_r * k_r);
          r3_r  <= 18'(rr_r * r_w);
          kkd_r <= 18'(kk_r * d_r);
          kdd_r <= 18'(dd_r * k_r);
          d3_r  <= 18'(dd_r * d_r);
        end
        2'd2: begin
          w_r[0] <= 20'(r3_r);
          w_r[1] <= w1_s[19:0];
          w_r[2] <= w2_s[19:0];
          w_r[3] <= 20'(k3_r);
          den_r  <= 21'(6 * d3_r);
        end
        default: begin
        end
      endcase
    end
  end

  // multiply-accumulate, then restoring divide, one lane per coordinate
  always_ff @(posedge clk) begin
    for (int c = 0; c < 2; c++) begin
      logic signed [55:0] mag;
      logic [55:0]        num;
      logic [22:0]        diff;
      mag  = acc_r[c][55] ? -acc_r[c] : acc_r[c];
      num  = 56'(mag) + 56'(den_r[20:1]);
      diff = {1'b0, rem_r[c], lo_r[c][31]} - {2'b0, den_r};
      if (cmd.mac) begin
        if (cmd.step < 6'd4)
          prod_r[c] <= 53'($signed({1'b0, w_r[cmd.step[1:0]]}) * p_r[c][cmd.step[1:0]]);
        if (cmd.step == 6'd0) acc_r[c] <= '0;
        else if (cmd.step < 6'd5) acc_r[c] <= acc_r[c] + 56'(prod_r[c]);
        else begin
          neg_r[c] <= acc_r[c][55];
          rem_r[c] <= num[52:32];
          lo_r[c]  <= num[31:0];
        end
      end
      if (cmd.div) begin
        rem_r[c] <= diff[22] ? {rem_r[c][19:0], lo_r[c][31]} : diff[20:0];
        lo_r[c]  <= {lo_r[c][30:0], 1'b0};
        q_r[c]   <= {q_r[c][30:0], ~diff[22]};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.err) begin
      out_x_out      <= '0;
      out_y_out      <= '0;
      out_run_last   <= 1'b1;
      out_curve_last <= 1'b0;
      out_status     <= st.empty ? ST_EMPTY : ST_DONE;
    end else if (cmd.fin) begin
      out_x_out      <= sat32(neg_r[0], q_r[0]);
      out_y_out      <= sat32(neg_r[1], q_r[1]);
      out_run_last   <= (k_r == kmax_r);
      out_curve_last <= (k_r == kmax_r) && last_seg_r;
      out_status     <= ST_OK;
    end
  end

endmodule

[src/closed_bspline_smoother.sv]
// closed_bspline_smoother: top level, closed uniform cubic b-spline over a point ring
// depends on cbs_pkg, cbs_ctrl, cbs_dp
//
// channel | ports                                        | handshake
// in      | in_func, in_x_in, in_y_in                    | in_valid / in_stall
// out     | out_x_out, out_y_out, out_run_last,
//         | out_curve_last, out_status                   | out_valid / out_stall
// cfg     | cfg_density                                  | cfg_valid / cfg_ready
//
// clear and append act on their input transfer; an error emit gives its result the next cycle
// each curve point passes through weight generation, multiply-accumulate, the divider,
// the result load and the output transfer
// a segment adds ring reads up front; the 32-step divider sets the pace
// reset is synchronous, active low; density returns to 8, ring empty
// while a result is stalled the block holds it and takes no new item
`timescale 1ns / 1ps
module closed_bspline_smoother (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_x_in,
  input  logic signed [31:0] in_y_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x_out,
  output logic signed [31:0] out_y_out,
  output logic               out_run_last,
  output logic               out_curve_last,
  output logic [1:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [5:0]         cfg_density
);
  import cbs_pkg::*;

  cbs_cmd_t  cmd;
  cbs_stat_t st;

  // sequencer
  cbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .st        (st)
  );

  // arithmetic and storage
  cbs_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .cfg_valid      (cfg_valid),
    .cfg_density    (cfg_density),
    .in_x_in        (in_x_in),
    .in_y_in        (in_y_in),
    .out_x_out      (out_x_out),
    .out_y_out      (out_y_out),
    .out_run_last   (out_run_last),
    .out_curve_last (out_curve_last),
    .out_status     (out_status)
  );

  // result consistency checks
  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_run_last && !out_curve_last &&
    out_x_out == 32'sd0 && out_y_out == 32'sd0)
    else $error("error result carries data");
  a_curve_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_curve_last |-> out_run_last)
    else $error("curve end without run end");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

endmodule
